[design/bw_pkg.sv]
// Shared constants, width helpers and the stage control type for barycentric_weights.
package bw_pkg;

   localparam int PIX_WIDTH       = 11;
   localparam int WEIGHT_WIDTH    = 19;
   localparam int QUOT_BITS       = 19;
   localparam int AREA_STAGES     = 3;
   localparam int LANE_STAGES     = QUOT_BITS + 3;
   localparam int PIPE_DEPTH      = AREA_STAGES + LANE_STAGES;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int COORD_FRAC_DEF  = 4;
   localparam int WEIGHT_FRAC_DEF = 16;

   typedef struct packed {
      logic [PIPE_DEPTH-1:0] en;
      logic [PIPE_DEPTH-1:0] valid;
   } stage_ctl_type;

   // signed width of a coordinate difference (vertex minus vertex or scaled pixel)
   function automatic int diff_width(input int coord_width, input int coord_frac);
      int scaled;
      scaled = PIX_WIDTH + coord_frac + 1;
      return ((coord_width > scaled) ? coord_width : scaled) + 1;
   endfunction

   function automatic int area_width(input int coord_width, input int coord_frac);
      return 2 * diff_width(coord_width, coord_frac) + 1;
   endfunction

endpackage

[design/barycentric_weights.sv]
// Top level of the barycentric weight pipeline for one triangle and one pixel per transfer.
//
// Input stream (req_): one transfer carries the three vertices of a triangle in signed
// fixed point and an integer pixel position. Output stream (rsp_): one transfer per input,
// in order, with the weights of A, B and C in signed fixed point (WEIGHT_FRAC fraction
// bits), rounded to nearest and saturated to 19 bits, plus a degenerate flag (zero area,
// weights zero) and a clipped flag (some weight saturated).
// Throughput: one transfer per clock unless every stage is full and rsp_tready is low.
// The work runs through 25 register stages: three for the differences, the 17x17 products
// and the areas, then per weight a magnitude stage, a range check, 19 restoring-division
// stages of one quotient bit each, and a rounding stage that is also the output register.
// When rsp_tready is low the result holds and stages behind it keep filling any empty
// slot; req_tready drops only once every stage holds an item.
// Reset (synchronous) empties the pipeline; rsp_tvalid is low in the cycle after it.
module barycentric_weights #(
   parameter  int COORD_WIDTH = bw_pkg::COORD_WIDTH_DEF,
   parameter  int COORD_FRAC  = bw_pkg::COORD_FRAC_DEF,
   parameter  int WEIGHT_FRAC = bw_pkg::WEIGHT_FRAC_DEF,
   localparam int ReqBits     = 6 * COORD_WIDTH + 2 * bw_pkg::PIX_WIDTH,
   localparam int ReqWidth    = ((ReqBits + 7) / 8) * 8,
   localparam int RspBits     = 3 * bw_pkg::WEIGHT_WIDTH,
   localparam int RspWidth    = ((RspBits + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqWidth-1:0] req_tdata,   // ax, ay, bx, by, cx, cy, px, py
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspWidth-1:0] rsp_tdata,   // weight_a, weight_b, weight_c
   output logic [1:0]          rsp_tuser    // degenerate, clipped
);

   localparam int Cw        = COORD_WIDTH;
   localparam int Pw        = bw_pkg::PIX_WIDTH;
   localparam int Ww        = bw_pkg::WEIGHT_WIDTH;
   localparam int AreaWidth = bw_pkg::area_width(COORD_WIDTH, COORD_FRAC);
   localparam int Depth     = bw_pkg::PIPE_DEPTH;
   localparam int AreaSt    = bw_pkg::AREA_STAGES;
   localparam logic [Ww-1:0] WtMax = {1'b0, {(Ww - 1){1'b1}}};
   localparam logic [Ww-1:0] WtMin = {1'b1, {(Ww - 1){1'b0}}};

   bw_pkg::stage_ctl_type ctl;

   logic signed [Cw-1:0] ax, ay, bx, by, cx, cy;
   logic [Pw-1:0]        px, py;

   logic signed [AreaWidth-1:0] whole, sub_a, sub_b, sub_c;
   logic signed [Ww-1:0]        weight_a, weight_b, weight_c;
   logic                        clip_a, clip_b, clip_c;
   logic                        degen_a, degen_b, degen_c;
   logic                        degenerate, clipped;

   assign ax = req_tdata[0*Cw +: Cw];
   assign ay = req_tdata[1*Cw +: Cw];
   assign bx = req_tdata[2*Cw +: Cw];
   assign by = req_tdata[3*Cw +: Cw];
   assign cx = req_tdata[4*Cw +: Cw];
   assign cy = req_tdata[5*Cw +: Cw];
   assign px = req_tdata[6*Cw +: Pw];
   assign py = req_tdata[6*Cw+Pw +: Pw];

   bw_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .ctl       (ctl)
   );

   bw_area #(
      .COORD_WIDTH (COORD_WIDTH),
      .COORD_FRAC  (COORD_FRAC)
   ) u_area (
      .clock (clock),
      .en    (ctl.en[AreaSt-1:0]),
      .ax    (ax),
      .ay    (ay),
      .bx    (bx),
      .by    (by),
      .cx    (cx),
      .cy    (cy),
      .px    (px),
      .py    (py),
      .whole (whole),
      .sub_a (sub_a),
      .sub_b (sub_b),
      .sub_c (sub_c)
   );

   bw_div #(
      .AREA_WIDTH  (AreaWidth),
      .WEIGHT_FRAC (WEIGHT_FRAC)
   ) u_div_a (
      .clock      (clock),
      .en         (ctl.en[Depth-1:AreaSt]),
      .sub        (sub_a),
      .whole      (whole),
      .weight     (weight_a),
      .clipped    (clip_a),
      .degenerate (degen_a)
   );

   bw_div #(
      .AREA_WIDTH  (AreaWidth),
      .WEIGHT_FRAC (WEIGHT_FRAC)
   ) u_div_b (
      .clock      (clock),
      .en         (ctl.en[Depth-1:AreaSt]),
      .sub        (sub_b),
      .whole      (whole),
      .weight     (weight_b),
      .clipped    (clip_b),
      .degenerate (degen_b)
   );

   bw_div #(
      .AREA_WIDTH  (AreaWidth),
      .WEIGHT_FRAC (WEIGHT_FRAC)
   ) u_div_c (
      .clock      (clock),
      .en         (ctl.en[Depth-1:AreaSt]),
      .sub        (sub_c),
      .whole      (whole),
      .weight     (weight_c),
      .clipped    (clip_c),
      .degenerate (degen_c)
   );

   // all lanes see the same whole area
   assign degenerate = degen_a & degen_b & degen_c;
   assign clipped    = clip_a | clip_b | clip_c;

   assign rsp_tdata = RspWidth'({weight_c, weight_b, weight_a});
   assign rsp_tuser = {clipped, degenerate};

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         weight_a == '0 && weight_b == '0 && weight_c == '0 && !rsp_tuser[1])
      else $error("degenerate result carries nonzero weight or clip");

   a_clip_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         weight_a == WtMax || weight_a == WtMin || weight_b == WtMax ||
         weight_b == WtMin || weight_c == WtMax || weight_c == WtMin)
      else $error("clipped result with no weight at a limit");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (&ctl.valid) && !rsp_tready |-> !req_tready)
      else $error("input taken while every stage is full and output stalled");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

endmodule

[design/bw_flow.sv]
// Pipeline valid bits and enables; a stage loads on out_ready or if it or a later stage is empty.
module bw_flow (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bw_pkg::stage_ctl_type ctl
);

   localparam int Depth = bw_pkg::PIPE_DEPTH;

   logic [Depth-1:0] valid_ff;
   logic [Depth-1:0] valid_in;
   logic [Depth-1:0] ready;
   logic [Depth-1:0] src_valid;

   for (genvar i = 0; i < Depth; i++) begin : g_stage
      // bubbles anywhere downstream let this stage move
      assign ready[i] = out_ready | ~(&valid_ff[Depth-1:i]);
      if (i == 0) begin : g_first
         assign src_valid[i] = in_valid;
      end else begin : g_rest
         assign src_valid[i] = valid_ff[i-1];
      end
      assign valid_in[i] = ready[i] ? src_valid[i] : valid_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.en    = ready;
   assign ctl.valid = valid_ff;
   assign in_ready  = ready[0];
   assign out_valid = valid_ff[Depth-1];

endmodule

[design/bw_area.sv]
// Differences, products and doubled signed areas of ABC, PBC, APC and ABP over three stages.
module bw_area #(
   parameter  int COORD_WIDTH = bw_pkg::COORD_WIDTH_DEF,
   parameter  int COORD_FRAC  = bw_pkg::COORD_FRAC_DEF,
   localparam int DiffWidth   = bw_pkg::diff_width(COORD_WIDTH, COORD_FRAC),
   localparam int AreaWidth   = bw_pkg::area_width(COORD_WIDTH, COORD_FRAC)
) (
   input  logic                                clock,
   input  logic [bw_pkg::AREA_STAGES-1:0]      en,
   input  logic signed [COORD_WIDTH-1:0]       ax,
   input  logic signed [COORD_WIDTH-1:0]       ay,
   input  logic signed [COORD_WIDTH-1:0]       bx,
   input  logic signed [COORD_WIDTH-1:0]       by,
   input  logic signed [COORD_WIDTH-1:0]       cx,
   input  logic signed [COORD_WIDTH-1:0]       cy,
   input  logic [bw_pkg::PIX_WIDTH-1:0]        px,
   input  logic [bw_pkg::PIX_WIDTH-1:0]        py,
   output logic signed [AreaWidth-1:0]         whole,
   output logic signed [AreaWidth-1:0]         sub_a,
   output logic signed [AreaWidth-1:0]         sub_b,
   output logic signed [AreaWidth-1:0]         sub_c
);

   localparam int ScaledWidth = bw_pkg::PIX_WIDTH + COORD_FRAC;
   localparam int ProdWidth   = 2 * DiffWidth;

   logic [ScaledWidth-1:0] qx, qy;
   logic signed [DiffWidth-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e, qx_e, qy_e;

   logic signed [DiffWidth-1:0] d_bax_ff, d_cay_ff, d_cax_ff, d_bay_ff, d_bqx_ff;
   logic signed [DiffWidth-1:0] d_cqy_ff, d_cqx_ff, d_bqy_ff, d_qax_ff, d_qay_ff;
   logic signed [ProdWidth-1:0] prod_in [8];
   logic signed [ProdWidth-1:0] prod_ff [8];
   logic signed [AreaWidth-1:0] whole_in, sub_a_in, sub_b_in, sub_c_in;
   logic signed [AreaWidth-1:0] whole_ff, sub_a_ff, sub_b_ff, sub_c_ff;

   // pixel moved onto the vertex grid
   assign qx = ScaledWidth'(px) << COORD_FRAC;
   assign qy = ScaledWidth'(py) << COORD_FRAC;

   assign ax_e = DiffWidth'(ax);
   assign ay_e = DiffWidth'(ay);
   assign bx_e = DiffWidth'(bx);
   assign by_e = DiffWidth'(by);
   assign cx_e = DiffWidth'(cx);
   assign cy_e = DiffWidth'(cy);
   assign qx_e = DiffWidth'(qx);
   assign qy_e = DiffWidth'(qy);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d_bax_ff <= bx_e - ax_e;
         d_cay_ff <= cy_e - ay_e;
         d_cax_ff <= cx_e - ax_e;
         d_bay_ff <= by_e - ay_e;
         d_bqx_ff <= bx_e - qx_e;
         d_cqy_ff <= cy_e - qy_e;
         d_cqx_ff <= cx_e - qx_e;
         d_bqy_ff <= by_e - qy_e;
         d_qax_ff <= qx_e - ax_e;
         d_qay_ff <= qy_e - ay_e;
      end
   end

   always_comb begin
      prod_in[0] = d_bax_ff * d_cay_ff;   // ABC
      prod_in[1] = d_cax_ff * d_bay_ff;
      prod_in[2] = d_bqx_ff * d_cqy_ff;   // PBC
      prod_in[3] = d_cqx_ff * d_bqy_ff;
      prod_in[4] = d_qax_ff * d_cay_ff;   // APC
      prod_in[5] = d_cax_ff * d_qay_ff;
      prod_in[6] = d_bax_ff * d_qay_ff;   // ABP
      prod_in[7] = d_qax_ff * d_bay_ff;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod_ff <= prod_in;
      end
   end

   assign whole_in = AreaWidth'(prod_ff[0]) - AreaWidth'(prod_ff[1]);
   assign sub_a_in = AreaWidth'(prod_ff[2]) - AreaWidth'(prod_ff[3]);
   assign sub_b_in = AreaWidth'(prod_ff[4]) - AreaWidth'(prod_ff[5]);
   assign sub_c_in = AreaWidth'(prod_ff[6]) - AreaWidth'(prod_ff[7]);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         whole_ff <= whole_in;
         sub_a_ff <= sub_a_in;
         sub_b_ff <= sub_b_in;
         sub_c_ff <= sub_c_in;
      end
   end

   assign whole = whole_ff;
   assign sub_a = sub_a_ff;
   assign sub_b = sub_b_ff;
   assign sub_c = sub_c_ff;

endmodule

[design/bw_div.sv]
// One weight lane: magnitudes, range check, one quotient bit per stage, rounding and saturation.
module bw_div #(
   parameter int AREA_WIDTH  = bw_pkg::area_width(bw_pkg::COORD_WIDTH_DEF,
                                                  bw_pkg::COORD_FRAC_DEF),
   parameter int WEIGHT_FRAC = bw_pkg::WEIGHT_FRAC_DEF
) (
   input  logic                                   clock,
   input  logic [bw_pkg::LANE_STAGES-1:0]         en,
   input  logic signed [AREA_WIDTH-1:0]           sub,
   input  logic signed [AREA_WIDTH-1:0]           whole,
   output logic signed [bw_pkg::WEIGHT_WIDTH-1:0] weight,
   output logic                                   clipped,
   output logic                                   degenerate
);

   localparam int MagWidth = AREA_WIDTH;
   localparam int QuotBits = bw_pkg::QUOT_BITS;
   localparam int WtWidth  = bw_pkg::WEIGHT_WIDTH;
   localparam int NumWidth = MagWidth + WEIGHT_FRAC;
   localparam int CmpWidth = (NumWidth > MagWidth + QuotBits) ? NumWidth
                                                             : MagWidth + QuotBits;
   localparam logic [QuotBits:0] PosLimit = (QuotBits + 1)'((1 << (WtWidth - 1)) - 1);
   localparam logic [QuotBits:0] NegLimit = (QuotBits + 1)'(1 << (WtWidth - 1));
   localparam logic [WtWidth-1:0] WtMax   = {1'b0, {(WtWidth - 1){1'b1}}};
   localparam logic [WtWidth-1:0] WtMin   = {1'b1, {(WtWidth - 1){1'b0}}};

   // magnitude stage
   logic [MagWidth-1:0] sub_u, whole_u;
   logic [MagWidth-1:0] num_mag_in, den_mag_in;
   logic [MagWidth-1:0] num_mag_ff, den_mag_ff;
   logic                neg_mag_ff, zero_mag_ff;

   assign sub_u      = sub;
   assign whole_u    = whole;
   assign num_mag_in = sub_u[MagWidth-1] ? (~sub_u + 1'b1) : sub_u;
   assign den_mag_in = whole_u[MagWidth-1] ? (~whole_u + 1'b1) : whole_u;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         num_mag_ff  <= num_mag_in;
         den_mag_ff  <= den_mag_in;
         neg_mag_ff  <= sub_u[MagWidth-1] ^ whole_u[MagWidth-1];
         zero_mag_ff <= (whole_u == '0);
      end
   end

   // per-stage state of the long division; index 0 is after the range check
   logic [MagWidth-1:0] rem_ff  [QuotBits+1];
   logic [QuotBits-1:0] rest_ff [QuotBits+1];
   logic [QuotBits-1:0] quot_ff [QuotBits+1];
   logic [MagWidth-1:0] den_ff  [QuotBits+1];
   logic                neg_ff  [QuotBits+1];
   logic                zero_ff [QuotBits+1];
   logic                ovf_ff  [QuotBits+1];

   logic [CmpWidth-1:0] num_ext, den_ext;

   // quotient of 2^QuotBits or more saturates in either sign
   assign num_ext = CmpWidth'(num_mag_ff) << WEIGHT_FRAC;
   assign den_ext = CmpWidth'(den_mag_ff) << QuotBits;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rem_ff[0]  <= num_ext[MagWidth+QuotBits-1:QuotBits];
         rest_ff[0] <= num_ext[QuotBits-1:0];
         quot_ff[0] <= '0;
         den_ff[0]  <= den_mag_ff;
         neg_ff[0]  <= neg_mag_ff;
         zero_ff[0] <= zero_mag_ff;
         ovf_ff[0]  <= (num_ext >= den_ext);
      end
   end

   for (genvar k = 0; k < QuotBits; k++) begin : g_iter
      logic [MagWidth:0]   trial;
      logic                take;
      logic [MagWidth-1:0] rem_in;

      assign trial  = {rem_ff[k], rest_ff[k][QuotBits-1]};
      assign take   = (trial >= {1'b0, den_ff[k]});
      assign rem_in = take ? MagWidth'(trial - {1'b0, den_ff[k]}) : trial[MagWidth-1:0];

      always_ff @(posedge clock) begin
         if (en[2+k]) begin
            rem_ff[k+1]  <= rem_in;
            rest_ff[k+1] <= rest_ff[k] << 1;
            quot_ff[k+1] <= {quot_ff[k][QuotBits-2:0], take};
            den_ff[k+1]  <= den_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
         end
      end
   end

   // round half away from zero, then clamp
   logic                round_up;
   logic [QuotBits:0]   mag;
   logic                sat;
   logic [WtWidth-1:0]  mag_neg;
   logic [WtWidth-1:0]  weight_in;
   logic [WtWidth-1:0]  weight_ff;
   logic                clipped_ff, degenerate_ff;

   assign round_up = ({rem_ff[QuotBits], 1'b0} >= {1'b0, den_ff[QuotBits]});
   assign mag      = {1'b0, quot_ff[QuotBits]} + (QuotBits + 1)'(round_up);
   assign sat      = ovf_ff[QuotBits] |
                     (neg_ff[QuotBits] ? (mag > NegLimit) : (mag > PosLimit));
   assign mag_neg  = WtWidth'(0) - mag[WtWidth-1:0];

   always_comb begin
      if (zero_ff[QuotBits]) begin
         weight_in = '0;
      end else if (sat) begin
         weight_in = neg_ff[QuotBits] ? WtMin : WtMax;
      end else begin
         weight_in = neg_ff[QuotBits] ? mag_neg : mag[WtWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[QuotBits+2]) begin
         weight_ff     <= weight_in;
         clipped_ff    <= sat & ~zero_ff[QuotBits];
         degenerate_ff <= zero_ff[QuotBits];
      end
   end

   assign weight     = weight_ff;
   assign clipped    = clipped_ff;
   assign degenerate = degenerate_ff;

endmodule
